// ===== src/dual_biquad_crossfade_macros.svh =====
// ----------------------------------------------------------------------------
// dual_biquad_crossfade_macros
// Assertion macros used by the RTL of the dual biquad crossfade block.
// ----------------------------------------------------------------------------
`ifndef DUAL_BIQUAD_CROSSFADE_MACROS_SVH
`define DUAL_BIQUAD_CROSSFADE_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define DBQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequence is checked in the cycle after the antecedent.
`define DBQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/dbq_pkg.sv =====
// ----------------------------------------------------------------------------
// dbq_pkg
// Shared constants and types of the dual biquad crossfade block.
// ----------------------------------------------------------------------------
`default_nettype none

package dbq_pkg;

  localparam int unsigned SampleBitsDef   = 24;
  localparam int unsigned CoefFracBitsDef = 24;
  localparam int unsigned MixBits         = 17;
  localparam int unsigned CfgIdxBits      = 3;
  localparam int unsigned CfgDataBits     = 64;
  localparam int unsigned CoefBits        = 32;
  localparam int unsigned AccBits         = 64;
  localparam int unsigned MixOne          = 65536;

  // Register indexes.
  typedef enum logic [CfgIdxBits-1:0] {
    RegMainA0A1 = 3'd0,
    RegMainA2B1 = 3'd1,
    RegMainB2   = 3'd2,
    RegMainC0D0 = 3'd3,
    RegAltA0A1  = 3'd4,
    RegAltA2B1  = 3'd5,
    RegAltB2    = 3'd6,
    RegAltC0D0  = 3'd7
  } dbq_reg_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    StIdle,
    StMul,
    StAcc,
    StMix,
    StOut
  } dbq_state_e;

  // Signed saturating add of two 64-bit values.
  function automatic logic [AccBits:0] sat_add64(input logic signed [AccBits-1:0] a,
                                                 input logic signed [AccBits-1:0] b);
    logic signed [AccBits:0] s;
    logic clip;
    logic signed [AccBits-1:0] r;
    s = {a[AccBits-1], a} + {b[AccBits-1], b};
    clip = s[AccBits] != s[AccBits-1];
    if (!clip) begin
      r = s[AccBits-1:0];
    end else if (s[AccBits]) begin
      r = {1'b1, {(AccBits-1){1'b0}}};
    end else begin
      r = {1'b0, {(AccBits-1){1'b1}}};
    end
    return {clip, r};
  endfunction

endpackage

`default_nettype wire

// ===== src/dbq_stream_if.sv =====
// ----------------------------------------------------------------------------
// dbq_stream_if
// Valid/ready channel carrying a payload of a given type.
// ----------------------------------------------------------------------------
`default_nettype none

interface dbq_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== src/dual_biquad_crossfade.sv =====
// Dual biquad crossfade.
// One input transaction carries a signed sample and a mix fraction (mix/65536,
// values above 65536 count as 65536). Two direct-form-1 biquads, main and
// alternate, filter the sample; their outputs are crossfaded into one
// saturated sample, and clipped flags any saturation on the way.
// Coefficients are written through the plain configuration port; the user
// must write them only while idle, as the block does not enforce it.
// All products go through one bit-serial multiplier, one multiplier bit per
// cycle (start, 32 bits, done); a sample needs 16 products (five taps, wet
// and dry gain per filter, two mix terms) and four rounding steps. One
// sample is in work at a time; the next is accepted in the cycle after the
// result has moved into the output register. The result waits in that
// output register while the receiver stalls; a finished sample behind it
// holds the sequencer and the input stays stalled. Reset clears the filter
// histories and loads unity wet gain, zero taps.
// ----------------------------------------------------------------------------
// dual_biquad_crossfade
// Top level: sequencer, histories, coefficient registers, serial multiplier.
// ----------------------------------------------------------------------------
`default_nettype none
`include "dual_biquad_crossfade_macros.svh"

module dual_biquad_crossfade #(
  parameter int unsigned SampleBits   = dbq_pkg::SampleBitsDef,
  parameter int unsigned CoefFracBits = dbq_pkg::CoefFracBitsDef
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  cfg_we_i,
  input  wire logic [dbq_pkg::CfgIdxBits-1:0]        cfg_idx_i,
  input  wire logic [dbq_pkg::CfgDataBits-1:0]       cfg_data_i,
  dbq_stream_if.sink                                 in_if,
  dbq_stream_if.source                               out_if
);
  import dbq_pkg::*;

  localparam int unsigned MulB = 32;                 // multiplier width (coefficient side)
  localparam int unsigned MulA = 32;
  localparam int unsigned CntBits = 4;
  localparam logic signed [AccBits-1:0] RoundC =
    AccBits'(64'sd1 <<< (CoefFracBits - 1));

  // Coefficient registers.
  logic [CfgDataBits-1:0] cfg_q [8];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) begin
        cfg_q[i] <= (i == int'(RegMainC0D0) || i == int'(RegAltC0D0)) ?
                    64'd1 << (CoefFracBits + 32) : '0;
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i == RegMainB2 || cfg_idx_i == RegAltB2) begin
        cfg_q[cfg_idx_i] <= {32'd0, cfg_data_i[31:0]};
      end else begin
        cfg_q[cfg_idx_i] <= cfg_data_i;
      end
    end
  end

  // Histories and per-sample working registers.
  logic signed [SampleBits-1:0] x_q, x1_q, x2_q;
  logic signed [SampleBits-1:0] ym1_q, ym2_q, ya1_q, ya2_q;
  logic signed [SampleBits-1:0] ym_q;
  logic [MixBits-1:0]           mix_q;
  logic signed [AccBits-1:0]    acc_q, acc_d;
  logic signed [31:0]           w_q, w_d;
  logic                         clip_q, clip_d;
  logic [CntBits-1:0]           step_q, step_d;
  logic                         filt_q, filt_d;     // 0 main, 1 alternate
  dbq_state_e                   state_q, state_d;
  logic                         ovalid_q, ovalid_d;
  logic signed [SampleBits-1:0] out_q;
  logic                         oclip_q;

  // Multiplier operands chosen by step.
  logic signed [MulA-1:0] mul_a;
  logic signed [MulB-1:0] mul_b;
  logic                   mul_start;
  logic                   mul_done;
  logic signed [MulA+MulB-1:0] mul_p;

  logic [CfgDataBits-1:0] r0, r1, r2, r3;
  logic [MixBits-1:0]     mix_sat;

  always_comb begin
    r0 = filt_q ? cfg_q[RegAltA0A1] : cfg_q[RegMainA0A1];
    r1 = filt_q ? cfg_q[RegAltA2B1] : cfg_q[RegMainA2B1];
    r2 = filt_q ? cfg_q[RegAltB2]   : cfg_q[RegMainB2];
    r3 = filt_q ? cfg_q[RegAltC0D0] : cfg_q[RegMainC0D0];
    mix_sat = (mix_q > MixBits'(MixOne)) ? MixBits'(MixOne) : mix_q;
    mul_a = '0;
    mul_b = '0;
    case (step_q)
      4'd0: begin mul_a = MulA'(x_q);  mul_b = r0[63:32]; end
      4'd1: begin mul_a = MulA'(x1_q); mul_b = r0[31:0];  end
      4'd2: begin mul_a = MulA'(x2_q); mul_b = r1[63:32]; end
      4'd3: begin mul_a = filt_q ? MulA'(ya1_q) : MulA'(ym1_q); mul_b = r1[31:0]; end
      4'd4: begin mul_a = filt_q ? MulA'(ya2_q) : MulA'(ym2_q); mul_b = r2[31:0]; end
      4'd5: begin mul_a = w_q;         mul_b = r3[63:32]; end
      4'd6: begin mul_a = MulA'(x_q);  mul_b = r3[31:0];  end
      4'd7: begin mul_a = MulA'(ym_q); mul_b = MulB'(MixOne) - MulB'(mix_sat); end
      4'd8: begin mul_a = filt_q ? MulA'(ya1_q) : MulA'(ym1_q); mul_b = MulB'(mix_sat); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  dbq_serial_mul #(.ABits(MulA), .BBits(MulB)) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .p_o    (mul_p)
  );

  // Rounding and clamping helpers on the accumulator.
  logic [AccBits:0]           add_r, rnd_r;
  logic signed [AccBits-1:0]  addend, shifted;
  logic                       w_clip, y_clip;
  logic signed [SampleBits-1:0] y_sat;
  logic signed [31:0]         w_sat;
  logic signed [AccBits-1:0]  mix_sh;
  logic signed [SampleBits-1:0] mix_out;
  logic                       mix_clip;
  localparam logic signed [AccBits-1:0] SMax = AccBits'((64'sd1 <<< (SampleBits-1)) - 1);
  localparam logic signed [AccBits-1:0] SMin = -SMax - 64'sd1;
  localparam logic signed [AccBits-1:0] WMax = 64'sd2147483647;
  localparam logic signed [AccBits-1:0] WMin = -64'sd2147483648;

  always_comb begin
    // Products of the feedback taps are subtracted. Their magnitude stays
    // well below 2^63, so the negation never overflows.
    if (step_q == 4'd3 || step_q == 4'd4) begin
      addend = -mul_p;
    end else begin
      addend = mul_p;
    end
    add_r   = sat_add64(acc_q, addend);
    rnd_r   = sat_add64(acc_q, RoundC);
    shifted = $signed(rnd_r[AccBits-1:0]) >>> CoefFracBits;
    w_clip  = (shifted > WMax) || (shifted < WMin);
    w_sat   = (shifted > WMax) ? 32'sh7fffffff :
              (shifted < WMin) ? 32'sh80000000 : shifted[31:0];
    y_clip  = (shifted > SMax) || (shifted < SMin);
    y_sat   = (shifted > SMax) ? SMax[SampleBits-1:0] :
              (shifted < SMin) ? SMin[SampleBits-1:0] : shifted[SampleBits-1:0];
    mix_sh  = (acc_q + 64'sd32768) >>> 16;
    mix_clip = (mix_sh > SMax) || (mix_sh < SMin);
    mix_out = (mix_sh > SMax) ? SMax[SampleBits-1:0] :
              (mix_sh < SMin) ? SMin[SampleBits-1:0] : mix_sh[SampleBits-1:0];
  end

  // Sequencer: next state and datapath updates.
  logic in_fire, out_fire;
  logic hist_upd_m, hist_upd_a, fin;

  assign in_fire  = in_if.valid && in_if.ready;
  assign out_fire = out_if.valid && out_if.ready;

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    filt_d     = filt_q;
    acc_d      = acc_q;
    w_d        = w_q;
    clip_d     = clip_q;
    ovalid_d   = ovalid_q;
    mul_start  = 1'b0;
    hist_upd_m = 1'b0;
    hist_upd_a = 1'b0;
    fin        = 1'b0;
    if (out_fire) begin
      ovalid_d = 1'b0;
    end
    case (state_q)
      StIdle: begin
        if (in_fire) begin
          state_d = StMul;
          step_d  = '0;
          filt_d  = 1'b0;
          acc_d   = '0;
          clip_d  = 1'b0;
        end
      end
      StMul: begin
        mul_start = 1'b1;
        state_d   = StAcc;
      end
      StAcc: begin
        if (mul_done) begin
          state_d = StMul;
          step_d  = step_q + 1'b1;
          case (step_q)
            4'd4: begin
              // Tap sum done: StMix then rounds it to sample units.
              clip_d = clip_q | add_r[AccBits];
              acc_d  = add_r[AccBits-1:0];
              state_d = StMix;
            end
            4'd5: begin
              acc_d = mul_p;
            end
            4'd6: begin
              clip_d = clip_q | add_r[AccBits];
              acc_d  = add_r[AccBits-1:0];
              state_d = StMix;
            end
            4'd7: begin
              acc_d = mul_p;
            end
            4'd8: begin
              acc_d   = acc_q + mul_p;
              state_d = StOut;
            end
            default: begin
              clip_d = clip_q | add_r[AccBits];
              acc_d  = add_r[AccBits-1:0];
            end
          endcase
        end
      end
      StMix: begin
        // Rounding step between phases.
        clip_d = clip_q | rnd_r[AccBits];
        if (step_q == 4'd5) begin
          clip_d = clip_q | rnd_r[AccBits] | w_clip;
          w_d    = w_sat;
          state_d = StMul;
        end else begin
          clip_d = clip_q | rnd_r[AccBits] | y_clip;
          acc_d  = '0;
          if (!filt_q) begin
            hist_upd_m = 1'b1;
            filt_d  = 1'b1;
            step_d  = '0;
            state_d = StMul;
          end else begin
            hist_upd_a = 1'b1;
            step_d  = 4'd7;
            state_d = StMul;
          end
        end
      end
      StOut: begin
        if (!ovalid_q || out_fire) begin
          fin      = 1'b1;
          ovalid_d = 1'b1;
          state_d  = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      ovalid_q <= 1'b0;
      step_q   <= '0;
      filt_q   <= 1'b0;
      x1_q     <= '0;
      x2_q     <= '0;
      ym1_q    <= '0;
      ym2_q    <= '0;
      ya1_q    <= '0;
      ya2_q    <= '0;
      clip_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
      step_q   <= step_d;
      filt_q   <= filt_d;
      clip_q   <= clip_d;
      if (hist_upd_m) begin
        ym2_q <= ym1_q;
        ym1_q <= y_sat;
      end
      if (hist_upd_a) begin
        ya2_q <= ya1_q;
        ya1_q <= y_sat;
        x2_q  <= x1_q;
        x1_q  <= x_q;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    w_q   <= w_d;
    if (in_fire) begin
      x_q   <= in_if.data.sample_in;
      mix_q <= in_if.data.mix;
    end
    if (hist_upd_m) begin
      ym_q <= y_sat;
    end
    if (fin) begin
      out_q   <= mix_out;
      oclip_q <= clip_q | mix_clip;
    end
  end

  assign in_if.ready          = (state_q == StIdle);
  assign out_if.valid         = ovalid_q;
  assign out_if.data.sample_out = out_q;
  assign out_if.data.clipped    = oclip_q;

  `DBQ_ASSERT_IMP(a_busy_no_ready, clk_i, rst_ni, state_q != StIdle, !in_if.ready, "ready while busy")
  `DBQ_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_if.valid && !out_if.ready, out_if.valid, "result dropped")
  `DBQ_ASSERT_NEXT(a_fin_valid, clk_i, rst_ni, fin, out_if.valid && state_q == StIdle, "finish lost")
endmodule

`default_nettype wire

// ===== src/dbq_serial_mul.sv =====
// ----------------------------------------------------------------------------
// dbq_serial_mul
// Shift-and-add signed multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dbq_serial_mul #(
  parameter int unsigned ABits = 32,
  parameter int unsigned BBits = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic signed [ABits-1:0]       a_i,
  input  wire logic signed [BBits-1:0]       b_i,
  output logic                               done_o,
  output logic signed [ABits+BBits-1:0]      p_o
);
  import dbq_pkg::*;

  localparam int unsigned PBits = ABits + BBits;
  localparam int unsigned CntBits = $clog2(BBits + 1);

  logic signed [PBits-1:0] acc_q, acc_d;
  logic signed [PBits-1:0] a_q, a_d;
  logic [BBits-1:0]        b_q, b_d;
  logic [CntBits-1:0]      cnt_q, cnt_d;
  logic                    busy_q, busy_d;
  logic                    done_q, done_d;

  // One multiplier bit per cycle; the sign bit carries negative weight.
  always_comb begin
    acc_d  = acc_q;
    a_d    = a_q;
    b_d    = b_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      acc_d  = '0;
      a_d    = PBits'(a_i);
      b_d    = b_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (b_q[0]) begin
        if (cnt_q == CntBits'(BBits - 1)) begin
          acc_d = acc_q - a_q;
        end else begin
          acc_d = acc_q + a_q;
        end
      end
      a_d   = a_q <<< 1;
      b_d   = b_q >> 1;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntBits'(BBits - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    a_q   <= a_d;
    b_q   <= b_d;
  end

  assign done_o = done_q;
  assign p_o    = acc_q;
endmodule

`default_nettype wire
